/* rtl/vpoc_pkg.sv */
// shared types, register indexes, reset values and constant-divide helpers
// for the valve pwm output conditioner; no dependencies
package vpoc_pkg;

   localparam int FsWidth   = 16;
   localparam int PctWidth  = 7;
   localparam int RawWidth  = 18;
   localparam int IdxWidth  = 3;
   localparam int ProdWidth = 23;
   localparam int CompWidth = 17;

   // register indexes
   localparam logic [IdxWidth-1:0] RegFullScale   = 3'd0;
   localparam logic [IdxWidth-1:0] RegDeadbandPct = 3'd1;
   localparam logic [IdxWidth-1:0] RegValveMin    = 3'd2;
   localparam logic [IdxWidth-1:0] RegValveMax    = 3'd3;
   localparam logic [IdxWidth-1:0] RegHystEnable  = 3'd4;
   localparam logic [IdxWidth-1:0] RegHystPct     = 3'd5;
   localparam logic [IdxWidth-1:0] RegWindupEn    = 3'd6;

   // reset values
   localparam logic [FsWidth-1:0]  FullScaleReset = 16'd16383;
   localparam logic [PctWidth-1:0] DeadbandReset  = 7'd1;
   localparam logic [PctWidth-1:0] ValveMinReset  = 7'd50;
   localparam logic [PctWidth-1:0] ValveMaxReset  = 7'd90;

   // reciprocal of full scale, scaled by 2^RecipShift
   localparam int RecipShift = 23;
   localparam int RecipWidth = RecipShift + 1;
   localparam logic [RecipWidth-1:0] RecipReset =
      RecipWidth'((64'd1 << RecipShift) / 64'(FullScaleReset));

   // divide by 100 as multiply by a rounded-up reciprocal
   localparam int Div100Shift = 30;
   localparam int Div100Width = 24;
   localparam logic [63:0] Div100Num = 64'd1 << Div100Shift;
   localparam logic [Div100Width-1:0] Recip100 =
      Div100Width'((Div100Num + 64'd99) / 64'd100);

   localparam logic [PctWidth-1:0] PctHundred = 7'd100;

   typedef struct packed {
      logic [FsWidth-1:0]   full_scale;
      logic [PctWidth-1:0]  deadband_pct;
      logic [PctWidth-1:0]  duty_min_pct;
      logic [PctWidth-1:0]  duty_max_pct;
      logic                 hyst_enable;
      logic [PctWidth-1:0]  hyst_pct;
      logic                 windup_enable;
      logic [ProdWidth-1:0] deadband_fs;
      logic [CompWidth-1:0] hyst_comp;
   } cfg_type;

   typedef struct packed {
      logic                loop_active;
      logic                pressure_safe;
      logic [FsWidth-1:0]  pressure;
      logic [RawWidth-1:0] ctrl_output;
   } req_item_type;

   typedef struct packed {
      logic               windup;
      logic               safe;
      logic               active;
      logic [FsWidth-1:0] cond;
   } shape_item_type;

   typedef struct packed {
      logic               shutdown;
      logic               windup_reset;
      logic [FsWidth-1:0] conditioned_output;
      logic [FsWidth-1:0] pwm_drive;
   } rsp_item_type;

   // floor(x / 100), exact for x below 2^23
   function automatic logic [CompWidth-1:0] div100(input logic [ProdWidth-1:0] x);
      logic [ProdWidth+Div100Width-1:0] p;
      p = {{Div100Width{1'b0}}, x} * {{ProdWidth{1'b0}}, Recip100};
      return p[Div100Shift +: CompWidth];
   endfunction

endpackage

/* rtl/vpoc_recip.sv */
// bit-serial reciprocal unit: floor(2^23 / full_scale), one quotient bit a cycle
// depends on vpoc_pkg
module vpoc_recip (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [vpoc_pkg::FsWidth-1:0]        divisor,
   output logic                                busy,
   output logic [vpoc_pkg::RecipWidth-1:0]     recip
);
   import vpoc_pkg::*;

   localparam int CntWidth = $clog2(RecipWidth);
   localparam logic [CntWidth-1:0] TopBit = CntWidth'(RecipWidth - 1);

   logic                  busy_ff;
   logic [CntWidth-1:0]   cnt_ff;
   logic [FsWidth:0]      rem_ff, rem_in;
   logic [FsWidth-1:0]    div_ff;
   logic [RecipWidth-1:0] quo_ff;
   logic [FsWidth:0]      rem_sh;
   logic                  qbit;

   always_comb begin
      rem_sh = {rem_ff[FsWidth-1:0], (cnt_ff == TopBit)};
      qbit   = (rem_sh >= {1'b0, div_ff});
      rem_in = qbit ? (rem_sh - {1'b0, div_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= RecipReset;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= TopBit;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[RecipWidth-2:0], qbit};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule

/* rtl/vpoc_shape.sv */
// front pipeline: input register, clamp, anti-windup detect, hysteresis offset
// holds the pressure, direction and previous-output state; depends on vpoc_pkg
module vpoc_shape (
   input  logic                     clock,
   input  logic                     reset,
   input  vpoc_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  vpoc_pkg::req_item_type   in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output vpoc_pkg::shape_item_type out_item
);
   import vpoc_pkg::*;

   logic [2:0] v_ff;
   logic [2:0] load;

   req_item_type s0_ff;

   logic [FsWidth-1:0]   s1_o_ff, s1_o_in;
   logic [ProdWidth-1:0] s1_o100_ff, s1_o100_in;
   logic                 s1_rising_ff, s1_rising_in;
   logic                 s1_safe_ff, s1_active_ff;

   shape_item_type s2_ff, s2_in;

   logic [FsWidth-1:0] last_pressure_ff;
   logic               pressure_rising_ff;
   logic [FsWidth-1:0] prev_output_ff;

   logic                 below;
   logic                 apply_hyst;
   logic [FsWidth:0]     diff;
   logic [FsWidth+1:0]   sum;
   logic [FsWidth-1:0]   o_hyst;

   always_comb begin
      load[2] = !v_ff[2] || out_ready;
      load[1] = !v_ff[1] || load[2];
      load[0] = !v_ff[0] || load[1];
   end

   // clamp to [0, full_scale] and pressure direction
   always_comb begin
      if (s0_ff.ctrl_output[RawWidth-1]) begin
         s1_o_in = '0;
      end else if (s0_ff.ctrl_output[RawWidth-2:0] > {1'b0, cfg.full_scale}) begin
         s1_o_in = cfg.full_scale;
      end else begin
         s1_o_in = s0_ff.ctrl_output[FsWidth-1:0];
      end
      s1_o100_in   = {{(ProdWidth-FsWidth){1'b0}}, s1_o_in} * ProdWidth'(PctHundred);
      s1_rising_in = s0_ff.pressure > last_pressure_ff;
   end

   // windup flag, hysteresis offset, conditioned output
   always_comb begin
      if (cfg.full_scale == '0) begin
         below = (cfg.deadband_pct != '0);
      end else begin
         below = s1_o100_ff < cfg.deadband_fs;
      end
      apply_hyst = s1_active_ff && cfg.hyst_enable && (s1_rising_ff != pressure_rising_ff);
      diff = {1'b0, s1_o_ff} - cfg.hyst_comp;
      sum  = {2'b0, s1_o_ff} + {1'b0, cfg.hyst_comp};
      if (s1_rising_ff) begin
         o_hyst = ({1'b0, s1_o_ff} < cfg.hyst_comp) ? '0 : diff[FsWidth-1:0];
      end else begin
         o_hyst = (sum > {2'b0, cfg.full_scale}) ? cfg.full_scale : sum[FsWidth-1:0];
      end
      s2_in.safe   = s1_safe_ff;
      s2_in.active = s1_active_ff;
      s2_in.windup = cfg.windup_enable && s1_active_ff &&
                     ((below && (s1_o_ff < prev_output_ff)) ||
                      ((s1_o_ff >= cfg.full_scale) && (s1_o_ff > prev_output_ff)));
      if (!s1_active_ff) begin
         s2_in.cond = prev_output_ff;
      end else if (apply_hyst) begin
         s2_in.cond = o_hyst;
      end else begin
         s2_in.cond = s1_o_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff               <= '0;
         last_pressure_ff   <= '0;
         pressure_rising_ff <= 1'b0;
         prev_output_ff     <= '0;
      end else begin
         if (load[0]) v_ff[0] <= in_valid;
         if (load[1]) v_ff[1] <= v_ff[0];
         if (load[2]) v_ff[2] <= v_ff[1];
         if (v_ff[0] && load[1]) begin
            last_pressure_ff <= s0_ff.pressure;
         end
         if (v_ff[1] && load[2]) begin
            prev_output_ff <= s2_in.cond;
            if (apply_hyst) begin
               pressure_rising_ff <= s1_rising_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_ff <= in_item;
      end
      if (load[1]) begin
         s1_o_ff      <= s1_o_in;
         s1_o100_ff   <= s1_o100_in;
         s1_rising_ff <= s1_rising_in;
         s1_safe_ff   <= s0_ff.pressure_safe;
         s1_active_ff <= s0_ff.loop_active;
      end
      if (load[2]) begin
         s2_ff <= s2_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = v_ff[2];
   assign out_item  = s2_ff;

endmodule

/* rtl/vpoc_duty.sv */
// back pipeline: whole percent of full scale, duty window mapping, drive select
// holds the last drive; last stage is the result register; depends on vpoc_pkg
module vpoc_duty (
   input  logic                              clock,
   input  logic                              reset,
   input  vpoc_pkg::cfg_type                 cfg,
   input  logic [vpoc_pkg::RecipWidth-1:0]   recip,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  vpoc_pkg::shape_item_type          in_item,
   output logic                              out_valid,
   input  logic                              out_ready,
   output vpoc_pkg::rsp_item_type            out_item
);
   import vpoc_pkg::*;

   localparam int NumStages = 8;

   typedef struct packed {
      logic [FsWidth-1:0]   cond;
      logic [ProdWidth-1:0] n100;
      logic [PctWidth-1:0]  q0;
      logic [ProdWidth-1:0] qf;
      logic [PctWidth-1:0]  pct;
      logic                 below;
      logic signed [15:0]   ps;
      logic [PctWidth-1:0]  mapped;
      logic [ProdWidth-1:0] mf;
      logic [FsWidth-1:0]   drive;
      logic                 windup;
      logic                 safe;
      logic                 active;
   } stage_type;

   logic [NumStages-1:0] v_ff;
   logic [NumStages:0]   load;
   stage_type            st_ff [NumStages];
   stage_type            st_in [NumStages];
   logic [FsWidth-1:0]   held_ff;

   logic [ProdWidth+RecipWidth-1:0] nm;
   logic [ProdWidth-1:0]            fsx;
   logic [ProdWidth-1:0]            rem;
   logic signed [7:0]               span;
   logic signed [15:0]              pct_s, span_s;
   logic [15:0]                     mag;
   logic [CompWidth-1:0]            qd_full;
   logic [PctWidth-1:0]             qd;
   logic signed [8:0]               sq, m9;
   logic [CompWidth-1:0]            duty_full;
   logic [FsWidth-1:0]              duty;

   always_comb begin
      load[NumStages] = out_ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
   end

   always_comb begin
      fsx = {{(ProdWidth-FsWidth){1'b0}}, cfg.full_scale};

      // output times 100
      st_in[0]        = '0;
      st_in[0].cond   = in_item.cond;
      st_in[0].windup = in_item.windup;
      st_in[0].safe   = in_item.safe;
      st_in[0].active = in_item.active;
      st_in[0].n100   = {{(ProdWidth-FsWidth){1'b0}}, in_item.cond} * ProdWidth'(PctHundred);

      // quotient estimate through the reciprocal, low by at most one
      st_in[1]    = st_ff[0];
      nm          = {{RecipWidth{1'b0}}, st_ff[0].n100} * {{ProdWidth{1'b0}}, recip};
      st_in[1].q0 = nm[RecipShift +: PctWidth];

      st_in[2]    = st_ff[1];
      st_in[2].qf = {{FsWidth{1'b0}}, st_ff[1].q0} * fsx;

      // correction step and deadband test
      st_in[3] = st_ff[2];
      rem      = st_ff[2].n100 - st_ff[2].qf;
      if (cfg.full_scale == '0) begin
         st_in[3].pct = '0;
      end else if (rem >= fsx) begin
         st_in[3].pct = st_ff[2].q0 + 1'b1;
      end else begin
         st_in[3].pct = st_ff[2].q0;
      end
      st_in[3].below = st_in[3].pct < cfg.deadband_pct;

      // percent times duty span
      st_in[4]    = st_ff[3];
      span        = $signed({1'b0, cfg.duty_max_pct}) - $signed({1'b0, cfg.duty_min_pct});
      pct_s       = $signed({9'b0, st_ff[3].pct});
      span_s      = {{8{span[7]}}, span};
      st_in[4].ps = pct_s * span_s;

      // signed divide by 100 toward zero, offset, clamp to [0, 100]
      st_in[5] = st_ff[4];
      mag      = st_ff[4].ps[15] ? 16'(-st_ff[4].ps) : 16'(st_ff[4].ps);
      qd_full  = div100({{(ProdWidth-16){1'b0}}, mag});
      qd       = qd_full[PctWidth-1:0];
      sq       = st_ff[4].ps[15] ? -$signed({2'b0, qd}) : $signed({2'b0, qd});
      m9       = $signed({2'b0, cfg.duty_min_pct}) + sq;
      if (m9 < 9'sd0) begin
         st_in[5].mapped = '0;
      end else if (m9 > $signed({2'b0, PctHundred})) begin
         st_in[5].mapped = PctHundred;
      end else begin
         st_in[5].mapped = m9[PctWidth-1:0];
      end

      st_in[6]    = st_ff[5];
      st_in[6].mf = {{FsWidth{1'b0}}, st_ff[5].mapped} * fsx;

      // drive select
      st_in[7]  = st_ff[6];
      duty_full = div100(st_ff[6].mf);
      duty      = duty_full[FsWidth-1:0];
      if (!st_ff[6].safe) begin
         st_in[7].drive = '0;
      end else if (!st_ff[6].active) begin
         st_in[7].drive = held_ff;
      end else if (st_ff[6].below) begin
         st_in[7].drive = '0;
      end else begin
         st_in[7].drive = duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         held_ff <= '0;
      end else begin
         if (load[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NumStages; k++) begin
            if (load[k]) v_ff[k] <= v_ff[k-1];
         end
         if (v_ff[NumStages-2] && load[NumStages-1]) begin
            held_ff <= st_in[NumStages-1].drive;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NumStages; k++) begin
         if (load[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = load[0];
   assign out_valid = v_ff[NumStages-1];

   always_comb begin
      out_item.pwm_drive          = st_ff[NumStages-1].drive;
      out_item.conditioned_output = st_ff[NumStages-1].cond;
      out_item.windup_reset       = st_ff[NumStages-1].windup;
      out_item.shutdown           = !st_ff[NumStages-1].safe;
   end

endmodule

/* rtl/valve_pwm_output_conditioner.sv */
// top level of the valve pwm output conditioner: register file, derived
// constants, reciprocal unit and the two pipeline halves
// depends on vpoc_pkg, vpoc_recip, vpoc_shape, vpoc_duty
//
// usage
//   req channel: one transaction per control tick, tdata holds from bit 0 up
//     ctrl_output[17:0] signed, pressure[33:18], pressure_safe[34],
//     loop_active[35], zero fill to 40 bits
//   rsp channel: one transaction per request, tdata holds from bit 0 up
//     pwm_drive[15:0], conditioned_output[31:16], windup_reset[32],
//     shutdown[33], zero fill to 40 bits
//   csr channel: csr_index selects the register, csr_data the value;
//     always ready, write only while no request is in flight;
//     req_tready is low while a csr write is offered
// the response comes from the 11-register pipeline (3 front, 8 back
// stages); one request is accepted every cycle while responses are taken
// and no csr write or reciprocal computation holds req_tready low
// a full_scale write starts the serial reciprocal unit, which computes
// one quotient bit a cycle; req_tready is low meanwhile
// reset clears valid bits and held state, loads the register defaults
// and the reciprocal reset value, so requests are taken right after reset
// a stalled response stays in the result register; the stages behind it
// keep filling bubbles and req_tready drops once every stage is full
module valve_pwm_output_conditioner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0] req_tdata,  // ctrl_output, pressure, pressure_safe, loop_active
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0] rsp_tdata,  // pwm_drive, conditioned_output, windup_reset, shutdown
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vpoc_pkg::IdxWidth-1:0]     csr_index,
   input  logic [vpoc_pkg::FsWidth-1:0]      csr_data
);
   import vpoc_pkg::*;

   cfg_type              cfg;
   logic [FsWidth-1:0]   full_scale_ff;
   logic [PctWidth-1:0]  deadband_ff, valve_min_ff, valve_max_ff, hyst_pct_ff;
   logic                 hyst_enable_ff, windup_enable_ff;
   logic [ProdWidth-1:0] deadband_fs_ff, hyst_prod_ff;
   logic [CompWidth-1:0] hyst_comp_ff;

   logic                  csr_write;
   logic                  recip_busy;
   logic [RecipWidth-1:0] recip;

   req_item_type   req_item;
   shape_item_type mid_item;
   rsp_item_type   rsp_item;
   logic           shape_ready, mid_valid, mid_ready;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff    <= FullScaleReset;
         deadband_ff      <= DeadbandReset;
         valve_min_ff     <= ValveMinReset;
         valve_max_ff     <= ValveMaxReset;
         hyst_enable_ff   <= 1'b0;
         hyst_pct_ff      <= '0;
         windup_enable_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            RegFullScale:   full_scale_ff    <= csr_data;
            RegDeadbandPct: deadband_ff      <= csr_data[PctWidth-1:0];
            RegValveMin:    valve_min_ff     <= csr_data[PctWidth-1:0];
            RegValveMax:    valve_max_ff     <= csr_data[PctWidth-1:0];
            RegHystEnable:  hyst_enable_ff   <= csr_data[0];
            RegHystPct:     hyst_pct_ff      <= csr_data[PctWidth-1:0];
            RegWindupEn:    windup_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // deadband threshold and hysteresis offset, refreshed every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_fs_ff <= ProdWidth'(FullScaleReset) * ProdWidth'(DeadbandReset);
         hyst_prod_ff   <= '0;
         hyst_comp_ff   <= '0;
      end else begin
         deadband_fs_ff <= {{(ProdWidth-FsWidth){1'b0}}, full_scale_ff} *
                           {{(ProdWidth-PctWidth){1'b0}}, deadband_ff};
         hyst_prod_ff   <= {{(ProdWidth-FsWidth){1'b0}}, full_scale_ff} *
                           {{(ProdWidth-PctWidth){1'b0}}, hyst_pct_ff};
         hyst_comp_ff   <= div100(hyst_prod_ff);
      end
   end

   always_comb begin
      cfg.full_scale    = full_scale_ff;
      cfg.deadband_pct  = deadband_ff;
      cfg.duty_min_pct  = valve_min_ff;
      cfg.duty_max_pct  = valve_max_ff;
      cfg.hyst_enable   = hyst_enable_ff;
      cfg.hyst_pct      = hyst_pct_ff;
      cfg.windup_enable = windup_enable_ff;
      cfg.deadband_fs   = deadband_fs_ff;
      cfg.hyst_comp     = hyst_comp_ff;
   end

   vpoc_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_write && (csr_index == RegFullScale)),
      .divisor (csr_data),
      .busy    (recip_busy),
      .recip   (recip)
   );

   assign req_item   = req_tdata[$bits(req_item_type)-1:0];
   assign req_tready = shape_ready && !recip_busy && !csr_valid;

   vpoc_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid && !recip_busy && !csr_valid),
      .in_ready  (shape_ready),
      .in_item   (req_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   vpoc_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .recip     (recip),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {{(40 - $bits(rsp_item_type)){1'b0}}, rsp_item};

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      recip_busy |-> !req_tready)
      else $error("request taken while reciprocal is being computed");

   a_fs_write_stalls: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == RegFullScale)) |=> !req_tready)
      else $error("full_scale write did not stall the request channel");

   a_shutdown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.shutdown) |-> (rsp_item.pwm_drive == '0))
      else $error("shutdown response with nonzero drive");

   a_windup_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.windup_reset) |-> windup_enable_ff)
      else $error("windup reset flagged while detection is disabled");

endmodule

/* bench/valve_pwm_output_conditioner_checker.sv */
// checker for the valve pwm output conditioner: watches the csr, req and rsp
// channels, predicts each response and compares it field by field
// depends on vpoc_pkg for register indexes, reset values and item layouts
module valve_pwm_output_conditioner_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [39:0]                   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [39:0]                   rsp_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [vpoc_pkg::IdxWidth-1:0] csr_index,
   input  logic [vpoc_pkg::FsWidth-1:0]  csr_data,
   output int                            mismatches,
   output int                            pending,
   output int                            checked,
   output int                            windups,
   output int                            shutdowns
);
   timeunit 1ns;
   timeprecision 1ps;
   import vpoc_pkg::*;

   longint full_scale;
   longint deadband;
   longint duty_min;
   longint duty_max;
   longint hyst_on;
   longint hyst_pct;
   longint windup_on;

   longint last_press;
   logic   press_rising;
   longint prev_cond;
   longint held_drive;

   rsp_item_type expected_rsp[$];

   function automatic longint percent_of_scale(longint v);
      if (full_scale == 0) return 0;
      return (v * 100) / full_scale;
   endfunction

   function automatic longint clamp_scale(longint v);
      if (v < 0) return 0;
      if (v > full_scale) return full_scale;
      return v;
   endfunction

   function automatic rsp_item_type condition_tick(req_item_type t);
      rsp_item_type r;
      longint raw;
      longint press;
      longint prev_press;
      longint o;
      longint pct;
      longint comp;
      longint span;
      longint mapped;
      longint cond;
      longint drive;
      logic   rising;
      logic   windup;
      raw = $signed(t.ctrl_output);
      press = t.pressure;
      prev_press = last_press;
      last_press = press;
      windup = 1'b0;
      if (t.loop_active) begin
         o = clamp_scale(raw);
         if (windup_on != 0) begin
            pct = percent_of_scale(o);
            if ((pct < deadband && o < prev_cond) || (o >= full_scale && o > prev_cond))
               windup = 1'b1;
         end
         if (hyst_on != 0) begin
            rising = press > prev_press;
            if (rising != press_rising) begin
               comp = (full_scale * hyst_pct) / 100;
               o = clamp_scale(rising ? o - comp : o + comp);
               press_rising = rising;
            end
         end
         cond = o;
         prev_cond = o;
         pct = percent_of_scale(o);
         if (pct < deadband) begin
            drive = 0;
         end else begin
            span = duty_max - duty_min;
            mapped = duty_min + (pct * span) / 100;
            if (mapped < 0) mapped = 0;
            if (mapped > 100) mapped = 100;
            drive = (mapped * full_scale) / 100;
         end
      end else begin
         cond = prev_cond;
         drive = held_drive;
      end
      if (!t.pressure_safe) drive = 0;
      held_drive = drive;
      r.pwm_drive = drive[15:0];
      r.conditioned_output = cond[15:0];
      r.windup_reset = windup;
      r.shutdown = !t.pressure_safe;
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         full_scale = FullScaleReset;
         deadband = DeadbandReset;
         duty_min = ValveMinReset;
         duty_max = ValveMaxReset;
         hyst_on = 0;
         hyst_pct = 0;
         windup_on = 0;
         last_press = 0;
         press_rising = 1'b0;
         prev_cond = 0;
         held_drive = 0;
         expected_rsp.delete();
         pending = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegFullScale:   full_scale = csr_data;
               RegDeadbandPct: deadband = csr_data[PctWidth-1:0];
               RegValveMin:    duty_min = csr_data[PctWidth-1:0];
               RegValveMax:    duty_max = csr_data[PctWidth-1:0];
               RegHystEnable:  hyst_on = csr_data[0];
               RegHystPct:     hyst_pct = csr_data[PctWidth-1:0];
               RegWindupEn:    windup_on = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("pwm_drive", want.pwm_drive, got.pwm_drive);
               check_field("conditioned_output", want.conditioned_output,
                           got.conditioned_output);
               check_field("windup_reset", want.windup_reset, got.windup_reset);
               check_field("shutdown", want.shutdown, got.shutdown);
               checked++;
               if (got.windup_reset) windups++;
               if (got.shutdown) shutdowns++;
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp.push_back(
               condition_tick(req_item_type'(req_tdata[$bits(req_item_type)-1:0])));
         pending = expected_rsp.size();
      end
   end

endmodule

/* bench/valve_pwm_output_conditioner_tb.sv */
// testbench top for the valve pwm output conditioner: clock, reset, register
// settings, directed and random control ticks, handshake stalls and verdict
// depends on vpoc_pkg, the block and valve_pwm_output_conditioner_checker
module valve_pwm_output_conditioner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit  = 3000;
   localparam int HoldCycles  = 300;
   localparam int RandomTicks = 190;
   localparam int NumPhases   = 10;
   localparam int NumDirected = 20;

   typedef struct packed {
      logic [15:0] fs;
      logic [6:0]  db;
      logic [6:0]  duty_min;
      logic [6:0]  duty_max;
      logic        hyst_on;
      logic [6:0]  hyst_pct;
      logic        windup_on;
   } reg_set_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [vpoc_pkg::IdxWidth-1:0] csr_index = '0;
   logic [vpoc_pkg::FsWidth-1:0]  csr_data = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [39:0] rsp_tdata;
   wire         csr_ready;

   int mismatches;
   int pending;
   int checked;
   int windups;
   int shutdowns;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int holds_asked = 0;
   int holds_granted = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int ticks_sent = 0;
   int press_walk = 0;

   int dir_ctrl[NumDirected] = '{0, 8000, 131071, -131072, 16383, 16384, 163, 164,
                                 12000, 5000, 12000, 0, 0, 1, 16382, 131071, -1,
                                 8191, 87381, -43691};
   int dir_press[NumDirected] = '{0, 100, 200, 150, 150, 65535, 0, 0, 10, 20, 30, 40,
                                  50, 60, 65535, 0, 32768, 32767, 43690, 21845};
   bit dir_safe[NumDirected] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 0, 1, 1, 0, 1, 1,
                                 1, 1};
   bit dir_active[NumDirected] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 0, 1, 1, 0, 1,
                                   1, 1, 0};

   valve_pwm_output_conditioner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   valve_pwm_output_conditioner_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked),
      .windups    (windups),
      .shutdowns  (shutdowns)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // response side: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles", StallLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_tick(logic [17:0] ctrl, logic [15:0] press, logic safe, logic active);
      vpoc_pkg::req_item_type t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      t.ctrl_output = ctrl;
      t.pressure = press;
      t.pressure_safe = safe;
      t.loop_active = active;
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, t};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   task automatic write_reg(logic [vpoc_pkg::IdxWidth-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic apply_settings(reg_set_type s);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (16) @(posedge clock);
      write_reg(vpoc_pkg::RegFullScale, s.fs);
      write_reg(vpoc_pkg::RegDeadbandPct, {9'($urandom_range(511)), s.db});
      write_reg(vpoc_pkg::RegValveMin, {9'($urandom_range(511)), s.duty_min});
      write_reg(vpoc_pkg::RegValveMax, {9'($urandom_range(511)), s.duty_max});
      write_reg(vpoc_pkg::RegHystEnable, {15'($urandom_range(32767)), s.hyst_on});
      write_reg(vpoc_pkg::RegHystPct, {9'($urandom_range(511)), s.hyst_pct});
      write_reg(vpoc_pkg::RegWindupEn, {15'($urandom_range(32767)), s.windup_on});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [6:0] random_pct();
      if ($urandom_range(9) == 0) return 7'($urandom_range(127, 101));
      return 7'($urandom_range(100));
   endfunction

   function automatic reg_set_type random_settings();
      reg_set_type s;
      int r;
      r = $urandom_range(99);
      if (r < 50)      s.fs = 16'($urandom_range(65535, 1));
      else if (r < 80) s.fs = 16'($urandom_range(300, 1));
      else             s.fs = 16'($urandom_range(65535, 60000));
      s.db = random_pct();
      s.duty_min = random_pct();
      s.duty_max = random_pct();
      s.hyst_on = 1'($urandom_range(1));
      s.hyst_pct = random_pct();
      s.windup_on = 1'($urandom_range(1));
      return s;
   endfunction

   task automatic send_random_tick(reg_set_type s);
      int r;
      int c;
      int fs_val;
      int db_count;
      fs_val = s.fs;
      db_count = fs_val * s.db / 100;
      r = $urandom_range(99);
      if (r < 45)      c = $urandom_range(fs_val, 0);
      else if (r < 60) c = db_count + int'($urandom_range(4)) - 2;
      else if (r < 72) c = fs_val + int'($urandom_range(6)) - 3;
      else if (r < 82) c = -int'($urandom_range(131072, 1));
      else if (r < 92) c = $urandom_range(262143);
      else if (r < 95) c = -131072;
      else if (r < 98) c = 131071;
      else             c = 0;
      r = $urandom_range(99);
      if (r < 30)      press_walk = press_walk + int'($urandom_range(500));
      else if (r < 60) press_walk = press_walk - int'($urandom_range(500));
      else if (r < 90) press_walk = $urandom_range(65535);
      else if (r < 95) press_walk = 0;
      else if (r < 98) press_walk = 65535;
      press_walk = press_walk & 16'hFFFF;
      send_tick(c[17:0], press_walk[15:0], $urandom_range(99) < 90, $urandom_range(99) < 85);
   endtask

   initial begin
      reg_set_type plan[NumPhases];
      plan[0] = '{16'd16383, 7'd1, 7'd50, 7'd90, 1'b1, 7'd10, 1'b1};
      plan[1] = '{16'd65535, 7'd0, 7'd0, 7'd100, 1'b1, 7'd100, 1'b1};
      plan[2] = '{16'd1, 7'd100, 7'd100, 7'd0, 1'b1, 7'd0, 1'b0};
      plan[3] = '{16'd0, 7'd127, 7'd127, 7'd127, 1'b1, 7'd127, 1'b1};
      plan[4] = '{16'd1000, 7'd5, 7'd90, 7'd10, 1'b1, 7'd3, 1'b1};
      for (int p = 5; p < NumPhases; p++) plan[p] = random_settings();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NumPhases; p++) begin
         if (p < 4) begin
            send_idle_pct = 35;
            rsp_idle_pct <= 46;
         end else if (p < 7) begin
            send_idle_pct = 46;
            rsp_idle_pct <= 35;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         apply_settings(plan[p]);
         if (p == 0)
            for (int i = 0; i < NumDirected; i++)
               send_tick(dir_ctrl[i][17:0], dir_press[i][15:0], dir_safe[i], dir_active[i]);
         for (int i = 0; i < RandomTicks; i++) begin
            if ((p == 1 || p == 8) && i == 60) holds_asked <= holds_asked + 1;
            send_random_tick(plan[p]);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);

      $display("run covered %0d control ticks under %0d register settings, zero to max scale",
               ticks_sent, NumPhases);
      $display("%0d responses compared, %0d with windup reset, %0d with shutdown",
               checked, windups, shutdowns);
      if (mismatches == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/vpoc_pkg.sv
rtl/vpoc_recip.sv
rtl/vpoc_shape.sv
rtl/vpoc_duty.sv
rtl/valve_pwm_output_conditioner.sv
bench/valve_pwm_output_conditioner_checker.sv
bench/valve_pwm_output_conditioner_tb.sv
